// ===== hdl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");

`endif

// ===== hdl/fcs_pkg.sv =====
`default_nettype none

package fcs_pkg;

  localparam logic [31:0] MAX_REQ_BYTES = 32'd4096;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] OPC_ERASE      = 2'd0;
  localparam logic [1:0] OPC_WRITE      = 2'd1;
  localparam logic [1:0] OPC_READ_START = 2'd2;
  localparam logic [1:0] OPC_READ_CONT  = 2'd3;

  localparam logic [1:0] KIND_ACCEPT = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_NODATA = 2'd2;
  localparam logic [1:0] KIND_FAIL   = 2'd3;

  localparam logic [1:0] SPLIT_ONLY   = 2'd0;
  localparam logic [1:0] SPLIT_FIRST  = 2'd1;
  localparam logic [1:0] SPLIT_MIDDLE = 2'd2;
  localparam logic [1:0] SPLIT_LAST   = 2'd3;

  localparam logic [1:0] FOP_NONE  = 2'd0;
  localparam logic [1:0] FOP_READ  = 2'd1;
  localparam logic [1:0] FOP_WRITE = 2'd2;
  localparam logic [1:0] FOP_ERASE = 2'd3;

  localparam logic [0:0] CFG_FLASH_BYTES = 1'b0;
  localparam logic [0:0] CFG_MAX_PAYLOAD = 1'b1;

  localparam logic [32:0] FLASH_BYTES_RESET = 33'd16777216;
  localparam logic [12:0] MAX_PAYLOAD_RESET = 13'd64;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] req_addr;
    logic [12:0] req_len;
    logic [3:0]  req_tag;
    logic [7:0]  req_port;
    logic        flash_failed;
  } req_t;

  typedef struct packed {
    logic [1:0]  completion_kind;
    logic [1:0]  split_type;
    logic [3:0]  out_tag;
    logic [7:0]  out_port;
    logic [12:0] op_length;
    logic [1:0]  flash_op;
    logic [31:0] flash_addr;
    logic        last;
  } cpl_t;

  typedef struct packed {
    logic [32:0] flash_bytes;
    logic [12:0] max_payload;
  } cfg_t;

  typedef struct packed {
    logic two;
    cpl_t first;
    cpl_t second;
  } job_t;

endpackage

`default_nettype wire

// ===== hdl/fcs_front.sv =====
`default_nettype none

module fcs_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire fcs_pkg::req_t req_data,
  input  wire fcs_pkg::cfg_t cfg,
  output logic               push,
  output fcs_pkg::job_t      push_data,
  input  wire logic          full
);

  fcs_pkg::req_t s_item;
  logic          s_valid;
  logic          s_range_fail;

  logic          read_busy;
  logic [7:0]    read_port;
  logic [3:0]    read_tag;
  logic [31:0]   read_base;
  logic [12:0]   read_total;
  logic [12:0]   read_done_bytes;
  logic [12:0]   read_payload_cap;

  logic          advance;
  logic          range_fail;
  logic [32:0]   range_end;
  logic          is_start;
  logic [7:0]    cur_port;
  logic [3:0]    cur_tag;
  logic [31:0]   cur_base;
  logic [12:0]   cur_total;
  logic [12:0]   cur_done;
  logic [12:0]   cur_cap;
  logic [12:0]   cap_eff;
  logic [12:0]   remaining;
  logic [12:0]   chunk;
  logic [31:0]   chunk_addr;
  logic [1:0]    split;
  logic [12:0]   done_sum;
  logic          read_ends;
  fcs_pkg::cpl_t chunk_cpl;
  logic          has_result;
  logic          start_ok;
  logic          cont_ok;

  function automatic fcs_pkg::cpl_t mk(
    input logic [1:0]  kind,
    input logic [1:0]  spl,
    input logic [3:0]  tag,
    input logic [7:0]  port,
    input logic [12:0] len,
    input logic [1:0]  fop,
    input logic [31:0] addr
  );
    fcs_pkg::cpl_t c;
    c.completion_kind = kind;
    c.split_type      = spl;
    c.out_tag         = tag;
    c.out_port        = port;
    c.op_length       = len;
    c.flash_op        = fop;
    c.flash_addr      = addr;
    c.last            = 1'b0;
    return c;
  endfunction

  // range check on the incoming request
  assign range_end  = {1'b0, req_data.req_addr} + {20'b0, req_data.req_len};
  assign range_fail = (range_end > cfg.flash_bytes) ||
                      ({19'b0, req_data.req_len} > fcs_pkg::MAX_REQ_BYTES);

  assign advance   = s_valid && !full;
  assign req_ready = !s_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (req_ready) begin
      s_valid <= req_valid;
    end
    if (req_ready && req_valid) begin
      s_item       <= req_data;
      s_range_fail <= range_fail;
    end
  end

  // chunk of the active read, or of the one being started
  assign cap_eff  = (cfg.max_payload == 13'd0) ? 13'd1 : cfg.max_payload;
  assign is_start = (s_item.opcode == fcs_pkg::OPC_READ_START);

  always_comb begin
    cur_port  = is_start ? s_item.req_port : read_port;
    cur_tag   = is_start ? s_item.req_tag : read_tag;
    cur_base  = is_start ? s_item.req_addr : read_base;
    cur_total = is_start ? s_item.req_len : read_total;
    cur_done  = is_start ? 13'd0 : read_done_bytes;
    cur_cap   = is_start ? cap_eff : read_payload_cap;

    remaining  = cur_total - cur_done;
    chunk      = (remaining < cur_cap) ? remaining : cur_cap;
    chunk_addr = cur_base + {19'b0, cur_done};
    done_sum   = cur_done + chunk;
    read_ends  = s_item.flash_failed || (done_sum >= cur_total);

    if (cur_total <= cur_cap) begin
      split = fcs_pkg::SPLIT_ONLY;
    end else if (cur_done == 13'd0) begin
      split = fcs_pkg::SPLIT_FIRST;
    end else if (remaining == chunk) begin
      split = fcs_pkg::SPLIT_LAST;
    end else begin
      split = fcs_pkg::SPLIT_MIDDLE;
    end

    if (s_item.flash_failed) begin
      chunk_cpl = mk(fcs_pkg::KIND_FAIL, fcs_pkg::SPLIT_ONLY, cur_tag, cur_port,
                     13'd0, fcs_pkg::FOP_READ, chunk_addr);
    end else begin
      chunk_cpl = mk(fcs_pkg::KIND_DATA, split, cur_tag, cur_port,
                     chunk, fcs_pkg::FOP_READ, chunk_addr);
    end
  end

  // classification into a job of one or two completions
  always_comb begin
    push_data  = '0;
    has_result = 1'b1;
    start_ok   = 1'b0;
    cont_ok    = 1'b0;
    if (s_range_fail) begin
      push_data.first = mk(fcs_pkg::KIND_FAIL, fcs_pkg::SPLIT_ONLY, s_item.req_tag,
                           s_item.req_port, 13'd0, fcs_pkg::FOP_NONE, 32'd0);
    end else begin
      case (s_item.opcode)
        fcs_pkg::OPC_ERASE, fcs_pkg::OPC_WRITE: begin
          push_data.two   = 1'b1;
          push_data.first = mk(fcs_pkg::KIND_ACCEPT, fcs_pkg::SPLIT_MIDDLE,
                               s_item.req_tag, s_item.req_port, 13'd0,
                               fcs_pkg::FOP_NONE, 32'd0);
          push_data.second = mk(
            s_item.flash_failed ? fcs_pkg::KIND_FAIL : fcs_pkg::KIND_NODATA,
            fcs_pkg::SPLIT_ONLY, s_item.req_tag, s_item.req_port,
            s_item.flash_failed ? 13'd0 : s_item.req_len,
            (s_item.opcode == fcs_pkg::OPC_ERASE) ? fcs_pkg::FOP_ERASE
                                                  : fcs_pkg::FOP_WRITE,
            s_item.req_addr);
        end
        fcs_pkg::OPC_READ_START: begin
          if (read_busy) begin
            push_data.first = mk(fcs_pkg::KIND_FAIL, fcs_pkg::SPLIT_ONLY,
                                 s_item.req_tag, s_item.req_port, 13'd0,
                                 fcs_pkg::FOP_NONE, 32'd0);
          end else begin
            start_ok         = 1'b1;
            push_data.two    = 1'b1;
            push_data.first  = mk(fcs_pkg::KIND_ACCEPT, fcs_pkg::SPLIT_MIDDLE,
                                  s_item.req_tag, s_item.req_port, 13'd0,
                                  fcs_pkg::FOP_NONE, 32'd0);
            push_data.second = chunk_cpl;
          end
        end
        default: begin
          if (read_busy) begin
            cont_ok         = 1'b1;
            push_data.first = chunk_cpl;
          end else begin
            has_result = 1'b0;
          end
        end
      endcase
    end
    push_data.first.last  = !push_data.two;
    push_data.second.last = 1'b1;
  end

  assign push = advance && has_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      read_busy <= 1'b0;
    end else if (advance && (start_ok || cont_ok)) begin
      read_busy <= !read_ends;
    end
    if (advance && start_ok) begin
      read_port        <= s_item.req_port;
      read_tag         <= s_item.req_tag;
      read_base        <= s_item.req_addr;
      read_total       <= s_item.req_len;
      read_payload_cap <= cap_eff;
    end
    if (advance && (start_ok || cont_ok)) begin
      read_done_bytes <= done_sum;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/fcs_queue.sv =====
`default_nettype none

module fcs_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire fcs_pkg::job_t push_data,
  output logic               full,
  input  wire logic          pop,
  output logic               not_empty,
  output fcs_pkg::job_t      head
);

  fcs_pkg::job_t                 entries [fcs_pkg::QUEUE_DEPTH];
  logic [fcs_pkg::QPTR_W-1:0]    wr_ptr;
  logic [fcs_pkg::QPTR_W-1:0]    rd_ptr;
  logic [fcs_pkg::QCNT_W-1:0]    count;

  localparam logic [fcs_pkg::QPTR_W-1:0] LAST_PTR =
    fcs_pkg::QPTR_W'(fcs_pkg::QUEUE_DEPTH - 1);
  localparam logic [fcs_pkg::QCNT_W-1:0] DEPTH_CNT =
    fcs_pkg::QCNT_W'(fcs_pkg::QUEUE_DEPTH);

  assign full      = (count == DEPTH_CNT);
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/fcs_back.sv =====
`default_nettype none

module fcs_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          not_empty,
  input  wire fcs_pkg::job_t head,
  output logic               pop,
  output logic               cpl_valid,
  input  wire logic          cpl_ready,
  output fcs_pkg::cpl_t      cpl_data
);

  logic          hold_valid;
  fcs_pkg::cpl_t hold;
  logic          load;

  assign load = !cpl_valid || cpl_ready;
  assign pop  = load && !hold_valid && not_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cpl_valid  <= 1'b0;
      hold_valid <= 1'b0;
    end else if (load) begin
      if (hold_valid) begin
        cpl_valid  <= 1'b1;
        hold_valid <= 1'b0;
      end else begin
        cpl_valid  <= not_empty;
        hold_valid <= not_empty && head.two;
      end
    end
    if (load) begin
      if (hold_valid) begin
        cpl_data <= hold;
      end else if (not_empty) begin
        cpl_data <= head.first;
        hold     <= head.second;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/flash_access_completion_splitter_unit.sv =====
// path: a taken request passes the front stage and the queue to the completion register
// throughput: one request per cycle for single completions while cpl_ready is high;
// a request that gives two sends them in turn through the one completion register
// reset: synchronous, clears the pipeline, the queue and the active read;
// flash size returns to 16 MiB and the payload cap to 64 bytes
`default_nettype none

`include "assert_macros.svh"

module flash_access_completion_splitter_unit (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire fcs_pkg::req_t req_data,
  output logic               cpl_valid,
  input  wire logic          cpl_ready,
  output fcs_pkg::cpl_t      cpl_data,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [0:0]    cfg_index,
  input  wire logic [32:0]   cfg_data
);

  fcs_pkg::cfg_t cfg;
  logic          q_push;
  fcs_pkg::job_t q_push_data;
  logic          q_full;
  logic          q_pop;
  logic          q_not_empty;
  fcs_pkg::job_t q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.flash_bytes <= fcs_pkg::FLASH_BYTES_RESET;
      cfg.max_payload <= fcs_pkg::MAX_PAYLOAD_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        fcs_pkg::CFG_FLASH_BYTES: cfg.flash_bytes <= cfg_data;
        fcs_pkg::CFG_MAX_PAYLOAD: cfg.max_payload <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  fcs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .cfg       (cfg),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full)
  );

  fcs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  fcs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .not_empty (q_not_empty),
    .head      (q_head),
    .pop       (q_pop),
    .cpl_valid (cpl_valid),
    .cpl_ready (cpl_ready),
    .cpl_data  (cpl_data)
  );

  `ASSERT_IMPLIES(a_queue_no_overflow, clk, rst, q_push, !q_full || q_pop)
  `ASSERT_IMPLIES(a_accept_not_last, clk, rst,
    cpl_valid && (cpl_data.completion_kind == fcs_pkg::KIND_ACCEPT), !cpl_data.last)
  `ASSERT_NEXT(a_accept_followed, clk, rst,
    cpl_valid && cpl_ready && (cpl_data.completion_kind == fcs_pkg::KIND_ACCEPT),
    cpl_valid && (cpl_data.out_tag == $past(cpl_data.out_tag)))

endmodule

`default_nettype wire

// ===== bench/flash_completion_checker.sv =====
`default_nettype none

module flash_completion_checker (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  input  wire logic          req_ready,
  input  wire fcs_pkg::req_t req_data,
  input  wire logic          cpl_valid,
  input  wire logic          cpl_ready,
  input  wire fcs_pkg::cpl_t cpl_data,
  input  wire logic          cfg_valid,
  input  wire logic          cfg_ready,
  input  wire logic [0:0]    cfg_index,
  input  wire logic [32:0]   cfg_data,
  output int                 fails,
  output int                 pending
);

  fcs_pkg::cpl_t cpl_expect_q[$];
  fcs_pkg::cpl_t want;
  int mism;

  logic [32:0] flash_bytes;
  logic [12:0] max_payload;

  // active read
  logic        rd_busy;
  logic [7:0]  rd_port;
  logic [3:0]  rd_tag;
  logic [31:0] rd_base;
  logic [12:0] rd_size;
  logic [12:0] rd_done;
  logic [12:0] rd_cap;

  function automatic fcs_pkg::cpl_t make_cpl(input logic [1:0] kind,
                                             input logic [1:0] split,
                                             input logic [3:0] tag, input logic [7:0] port,
                                             input logic [12:0] len, input logic [1:0] fop,
                                             input logic [31:0] addr);
    fcs_pkg::cpl_t c;
    c.completion_kind = kind;
    c.split_type      = split;
    c.out_tag         = tag;
    c.out_port        = port;
    c.op_length       = len;
    c.flash_op        = fop;
    c.flash_addr      = addr;
    c.last            = 1'b0;
    return c;
  endfunction

  function automatic string cpl_str(input fcs_pkg::cpl_t c);
    return $sformatf(
      "kind=%0d split=%0d tag=%0d port=%0d len=%0d fop=%0d addr=%h last=%0d",
      c.completion_kind, c.split_type, c.out_tag, c.out_port,
      c.op_length, c.flash_op, c.flash_addr, c.last);
  endfunction

  // next chunk of the active read, or its failure
  task automatic serve_chunk(input logic failed, output fcs_pkg::cpl_t c);
    logic [12:0] remaining;
    logic [12:0] chunk;
    logic [31:0] addr;
    logic [1:0]  split;
    remaining = rd_size - rd_done;
    chunk = (remaining < rd_cap) ? remaining : rd_cap;
    addr = rd_base + {19'b0, rd_done};
    if (failed) begin
      c = make_cpl(fcs_pkg::KIND_FAIL, fcs_pkg::SPLIT_ONLY, rd_tag, rd_port, 13'd0,
                   fcs_pkg::FOP_READ, addr);
      rd_busy = 1'b0;
    end else begin
      if (rd_size <= rd_cap) begin
        split = fcs_pkg::SPLIT_ONLY;
      end else if (rd_done == 13'd0) begin
        split = fcs_pkg::SPLIT_FIRST;
      end else if (remaining == chunk) begin
        split = fcs_pkg::SPLIT_LAST;
      end else begin
        split = fcs_pkg::SPLIT_MIDDLE;
      end
      c = make_cpl(fcs_pkg::KIND_DATA, split, rd_tag, rd_port, chunk, fcs_pkg::FOP_READ,
                   addr);
      rd_done = rd_done + chunk;
      if (rd_done >= rd_size) begin
        rd_busy = 1'b0;
      end
    end
  endtask

  task automatic predict_request(input fcs_pkg::req_t r);
    fcs_pkg::cpl_t res[2];
    int            n;
    logic [33:0]   span;
    logic [1:0]    fop;
    n = 0;
    span = {2'b0, r.req_addr} + {21'b0, r.req_len};
    if (span > {1'b0, flash_bytes} || {19'b0, r.req_len} > fcs_pkg::MAX_REQ_BYTES) begin
      res[0] = make_cpl(fcs_pkg::KIND_FAIL, fcs_pkg::SPLIT_ONLY, r.req_tag, r.req_port,
                        13'd0, fcs_pkg::FOP_NONE, 32'd0);
      n = 1;
    end else if (r.opcode == fcs_pkg::OPC_ERASE || r.opcode == fcs_pkg::OPC_WRITE) begin
      fop = (r.opcode == fcs_pkg::OPC_ERASE) ? fcs_pkg::FOP_ERASE : fcs_pkg::FOP_WRITE;
      res[0] = make_cpl(fcs_pkg::KIND_ACCEPT, fcs_pkg::SPLIT_MIDDLE, r.req_tag, r.req_port,
                        13'd0, fcs_pkg::FOP_NONE, 32'd0);
      if (r.flash_failed) begin
        res[1] = make_cpl(fcs_pkg::KIND_FAIL, fcs_pkg::SPLIT_ONLY, r.req_tag, r.req_port,
                          13'd0, fop, r.req_addr);
      end else begin
        res[1] = make_cpl(fcs_pkg::KIND_NODATA, fcs_pkg::SPLIT_ONLY, r.req_tag,
                          r.req_port, r.req_len, fop, r.req_addr);
      end
      n = 2;
    end else if (r.opcode == fcs_pkg::OPC_READ_START) begin
      if (rd_busy) begin
        res[0] = make_cpl(fcs_pkg::KIND_FAIL, fcs_pkg::SPLIT_ONLY, r.req_tag, r.req_port,
                          13'd0, fcs_pkg::FOP_NONE, 32'd0);
        n = 1;
      end else begin
        rd_busy = 1'b1;
        rd_port = r.req_port;
        rd_tag  = r.req_tag;
        rd_base = r.req_addr;
        rd_size = r.req_len;
        rd_done = 13'd0;
        rd_cap  = (max_payload == 13'd0) ? 13'd1 : max_payload;
        res[0] = make_cpl(fcs_pkg::KIND_ACCEPT, fcs_pkg::SPLIT_MIDDLE, r.req_tag,
                          r.req_port, 13'd0, fcs_pkg::FOP_NONE, 32'd0);
        serve_chunk(r.flash_failed, res[1]);
        n = 2;
      end
    end else if (rd_busy) begin
      serve_chunk(r.flash_failed, res[0]);
      n = 1;
    end
    if (n > 0) begin
      res[n - 1].last = 1'b1;
    end
    for (int i = 0; i < n; i++) begin
      cpl_expect_q.push_back(res[i]);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cpl_expect_q.delete();
      mism        = 0;
      flash_bytes = fcs_pkg::FLASH_BYTES_RESET;
      max_payload = fcs_pkg::MAX_PAYLOAD_RESET;
      rd_busy     = 1'b0;
      rd_port     = '0;
      rd_tag      = '0;
      rd_base     = '0;
      rd_size     = '0;
      rd_done     = '0;
      rd_cap      = '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == fcs_pkg::CFG_FLASH_BYTES) begin
          flash_bytes = cfg_data;
        end else begin
          max_payload = cfg_data[12:0];
        end
      end
      if (cpl_valid && cpl_ready) begin
        if (cpl_expect_q.size() == 0) begin
          if (mism < 10) begin
            $display("unexpected completion: %s", cpl_str(cpl_data));
          end
          mism++;
        end else begin
          want = cpl_expect_q.pop_front();
          if (cpl_data.completion_kind !== want.completion_kind ||
              cpl_data.split_type !== want.split_type ||
              cpl_data.out_tag !== want.out_tag ||
              cpl_data.out_port !== want.out_port ||
              cpl_data.op_length !== want.op_length ||
              cpl_data.flash_op !== want.flash_op ||
              cpl_data.flash_addr !== want.flash_addr ||
              cpl_data.last !== want.last) begin
            if (mism < 10) begin
              $display("completion mismatch: expected %s", cpl_str(want));
              $display("                     actual   %s", cpl_str(cpl_data));
            end
            mism++;
          end
        end
      end
      if (req_valid && req_ready) begin
        predict_request(req_data);
      end
    end
    fails   <= mism;
    pending <= cpl_expect_q.size();
  end

endmodule

`default_nettype wire

// ===== bench/flash_access_completion_splitter_unit_tb.sv =====
`default_nettype none

module flash_access_completion_splitter_unit_tb;

  localparam int STALL_LIMIT = 4000;

  logic          clk;
  logic          rst;
  logic          req_valid;
  logic          req_ready;
  fcs_pkg::req_t req_data;
  logic          cpl_valid;
  logic          cpl_ready;
  fcs_pkg::cpl_t cpl_data;
  logic          cfg_valid;
  logic          cfg_ready;
  logic [0:0]    cfg_index;
  logic [32:0]   cfg_data;

  int fails;
  int pending;
  int stall_cycles;

  // stimulus-side view of the device setup and the active read
  logic [32:0] cur_fb;
  logic [12:0] cur_cap;
  int          rd_left;
  bit          quiet;

  flash_access_completion_splitter_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .cpl_valid (cpl_valid),
    .cpl_ready (cpl_ready),
    .cpl_data  (cpl_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  flash_completion_checker chk (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .cpl_valid (cpl_valid),
    .cpl_ready (cpl_ready),
    .cpl_data  (cpl_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fails     (fails),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    cpl_ready = 1'b0;
    forever begin
      @(posedge clk);
      cpl_ready <= quiet || ($urandom_range(99) >= 8);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (cpl_valid && cpl_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic fcs_pkg::req_t make_request(input logic [1:0] opc,
                                                 input logic [31:0] addr,
                                                 input logic [12:0] len,
                                                 input logic [3:0] tag,
                                                 input logic [7:0] port,
                                                 input logic failed);
    fcs_pkg::req_t r;
    r.opcode       = opc;
    r.req_addr     = addr;
    r.req_len      = len;
    r.req_tag      = tag;
    r.req_port     = port;
    r.flash_failed = failed;
    return r;
  endfunction

  // address that keeps the request inside the flash when it fits, sometimes right at the end
  function automatic logic [31:0] pick_addr(input logic [12:0] len);
    logic [32:0] lim;
    if (cur_fb < {20'b0, len}) begin
      return $urandom;
    end
    lim = cur_fb - {20'b0, len};
    if (lim > 33'h0_FFFF_FFFF) begin
      lim = 33'h0_FFFF_FFFF;
    end
    if ($urandom_range(9) == 0) begin
      return lim[31:0];
    end
    return $urandom_range(lim[31:0], 0);
  endfunction

  // keeps count of the continues the active read still needs
  function automatic void note_read(input fcs_pkg::req_t r);
    logic [33:0] span;
    int          eff;
    int          chunks;
    span = {2'b0, r.req_addr} + {21'b0, r.req_len};
    if (span > {1'b0, cur_fb} || {19'b0, r.req_len} > fcs_pkg::MAX_REQ_BYTES) begin
      return;
    end
    eff = (cur_cap == 13'd0) ? 1 : int'(cur_cap);
    chunks = (int'(r.req_len) + eff - 1) / eff;
    if (r.opcode == fcs_pkg::OPC_READ_START && rd_left == 0) begin
      rd_left = (r.flash_failed || chunks == 0) ? 0 : chunks - 1;
    end else if (r.opcode == fcs_pkg::OPC_READ_CONT && rd_left > 0) begin
      rd_left = r.flash_failed ? 0 : rd_left - 1;
    end
  endfunction

  task automatic send_req(input fcs_pkg::req_t r);
    if (!quiet && $urandom_range(99) < 8) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    note_read(r);
    req_valid <= 1'b1;
    req_data  <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  task automatic finish_phase();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [32:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_phase(input logic [32:0] fb, input logic [12:0] cap, input int n,
                           input bit q);
    fcs_pkg::req_t r;
    int            made;
    int            pick;
    int            eff;
    int            top_len;
    logic [12:0]   len;
    logic [32:0]   lim;
    write_reg(fcs_pkg::CFG_FLASH_BYTES, fb);
    write_reg(fcs_pkg::CFG_MAX_PAYLOAD, {20'b0, cap});
    cur_fb  = fb;
    cur_cap = cap;
    quiet   = q;
    eff = (cap == 13'd0) ? 1 : int'(cap);
    top_len = (eff * 6 > 4096) ? 4096 : eff * 6;
    made = 0;
    while (made < n) begin
      pick = $urandom_range(99);
      r = make_request(fcs_pkg::OPC_ERASE, 32'd0, 13'd0, 4'($urandom), 8'($urandom), 1'b0);
      if (rd_left > 0 && pick < 75) begin
        // well-formed continue of the active read
        len = 13'($urandom_range(64, 0));
        r.opcode       = fcs_pkg::OPC_READ_CONT;
        r.req_len      = len;
        r.req_addr     = pick_addr(len);
        r.flash_failed = ($urandom_range(99) < 3);
      end else if ((rd_left > 0 && pick < 85) || (rd_left == 0 && pick < 30)) begin
        len = 13'($urandom_range(4096, 0));
        r.opcode       = $urandom_range(1) ? fcs_pkg::OPC_WRITE : fcs_pkg::OPC_ERASE;
        r.req_len      = len;
        r.req_addr     = pick_addr(len);
        r.flash_failed = ($urandom_range(99) < 10);
      end else if ((rd_left > 0 && pick < 90) || (rd_left == 0 && pick < 70)) begin
        if ($urandom_range(99) < 3) begin
          len = (eff >= 64) ? 13'd4096 : 13'(top_len);
        end else begin
          len = 13'($urandom_range(top_len, 0));
        end
        r.opcode       = fcs_pkg::OPC_READ_START;
        r.req_len      = len;
        r.req_addr     = pick_addr(len);
        r.flash_failed = ($urandom_range(99) < 3);
      end else if (rd_left == 0 && pick < 80) begin
        // right at the end of the flash or one byte past it
        len = 13'($urandom_range(4096, 0));
        r.opcode  = 2'($urandom_range(3));
        r.req_len = len;
        lim = (cur_fb >= {20'b0, len}) ? cur_fb - {20'b0, len} : 33'd0;
        r.req_addr     = lim[31:0] + 32'($urandom_range(1));
        r.flash_failed = 1'($urandom_range(1));
      end else begin
        r.opcode  = 2'($urandom_range(3));
        r.req_len = ($urandom_range(99) < 40) ? 13'($urandom_range(8191, 0))
                                              : 13'($urandom_range(4096, 0));
        r.req_addr     = $urandom_range(1) ? $urandom : pick_addr(r.req_len);
        r.flash_failed = 1'($urandom_range(1));
      end
      if (!(r.opcode == fcs_pkg::OPC_READ_CONT && rd_left == 0)) begin
        made++;
      end
      send_req(r);
    end
    finish_phase();
  endtask

  initial begin
    logic [32:0] rfb;
    logic [12:0] rcap;
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req_data  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    quiet      = 1'b0;
    rd_left    = 0;
    cur_fb     = fcs_pkg::FLASH_BYTES_RESET;
    cur_cap    = fcs_pkg::MAX_PAYLOAD_RESET;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed requests on the reset setup
    send_req(make_request(fcs_pkg::OPC_ERASE, 32'h0, 13'd0, 4'd0, 8'd0, 1'b0));
    send_req(make_request(fcs_pkg::OPC_WRITE, 32'h100, 13'd4096, 4'd15, 8'd255, 1'b0));
    // ends exactly at the flash size, flash error
    send_req(make_request(fcs_pkg::OPC_ERASE, 32'h00FF_F000, 13'd4096, 4'd3, 8'd1, 1'b1));
    send_req(make_request(fcs_pkg::OPC_WRITE, 32'h20, 13'd16, 4'd7, 8'd8, 1'b1));
    send_req(make_request(fcs_pkg::OPC_ERASE, 32'hFFFF_FFFF, 13'd4096, 4'd1, 8'd2, 1'b0));
    send_req(make_request(fcs_pkg::OPC_WRITE, 32'h0, 13'd4097, 4'd2, 8'd3, 1'b0));
    send_req(make_request(fcs_pkg::OPC_READ_CONT, 32'h0, 13'd8191, 4'd4, 8'd4, 1'b1));
    // continue with no read active
    send_req(make_request(fcs_pkg::OPC_READ_CONT, 32'h0, 13'd0, 4'd5, 8'd5, 1'b0));
    send_req(make_request(fcs_pkg::OPC_READ_START, 32'h10, 13'd0, 4'd6, 8'd6, 1'b0));
    send_req(make_request(fcs_pkg::OPC_READ_START, 32'h40, 13'd64, 4'd8, 8'd9, 1'b0));
    send_req(make_request(fcs_pkg::OPC_READ_START, 32'h1000, 13'd200, 4'd9, 8'd10, 1'b0));
    send_req(make_request(fcs_pkg::OPC_READ_CONT, 32'h0, 13'd0, 4'd1, 8'd77, 1'b0));
    // second read start while busy
    send_req(make_request(fcs_pkg::OPC_READ_START, 32'h80, 13'd8, 4'd10, 8'd11, 1'b0));
    send_req(make_request(fcs_pkg::OPC_WRITE, 32'h300, 13'd32, 4'd11, 8'd12, 1'b0));
    send_req(make_request(fcs_pkg::OPC_READ_CONT, 32'h0, 13'd0, 4'd2, 8'd78, 1'b0));
    send_req(make_request(fcs_pkg::OPC_READ_CONT, 32'h0, 13'd0, 4'd3, 8'd79, 1'b0));
    send_req(make_request(fcs_pkg::OPC_READ_CONT, 32'h0, 13'd0, 4'd4, 8'd80, 1'b0));
    send_req(make_request(fcs_pkg::OPC_READ_START, 32'h2000, 13'd130, 4'd12, 8'd13, 1'b0));
    // flash error in the middle of a read
    send_req(make_request(fcs_pkg::OPC_READ_CONT, 32'h0, 13'd0, 4'd5, 8'd81, 1'b1));
    send_req(make_request(fcs_pkg::OPC_READ_CONT, 32'h0, 13'd0, 4'd6, 8'd82, 1'b0));
    send_req(make_request(fcs_pkg::OPC_READ_START, 32'h00FF_FFC0, 13'd64, 4'd13, 8'd14,
                          1'b1));
    send_req(make_request(fcs_pkg::OPC_WRITE, 32'h00FF_FFF1, 13'd16, 4'd14, 8'd15, 1'b0));
    send_req(make_request(fcs_pkg::OPC_READ_START, 32'hFFFF_FFFF, 13'd0, 4'd15, 8'd200,
                          1'b0));
    finish_phase();

    run_phase({1'b1, 32'd0}, 13'd4096, 250, 1'b0);
    run_phase({1'b1, 32'd0}, 13'd1, 250, 1'b1);
    run_phase(33'd0, 13'd0, 60, 1'b0);
    run_phase(fcs_pkg::FLASH_BYTES_RESET, fcs_pkg::MAX_PAYLOAD_RESET, 300, 1'b0);
    for (int p = 0; p < 4; p++) begin
      if (p[0]) begin
        rfb = {1'b0, $urandom};
      end else begin
        rfb = {1'b0, $urandom_range(32'h0100_0000, 32'h0001_0000)};
      end
      if (p < 2) begin
        rcap = 13'($urandom_range(128, 1));
      end else begin
        rcap = 13'($urandom_range(4096, 1));
      end
      run_phase(rfb, rcap, 260, 1'b0);
    end

    repeat (20) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+hdl
hdl/fcs_pkg.sv
hdl/fcs_front.sv
hdl/fcs_queue.sv
hdl/fcs_back.sv
hdl/flash_access_completion_splitter_unit.sv
bench/flash_completion_checker.sv
bench/flash_access_completion_splitter_unit_tb.sv
